/* hdl/sgr_pkg.sv */
// Shared types, constants and code table for the SGR attribute change encoder.
`default_nettype none

package sgr_pkg;

   localparam int ATTR_W  = 13;
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 3;

   localparam logic [ATTR_W-1:0] VISIBLE_MASK = 13'h1BFF;  // all but the ignored bit
   localparam logic [ATTR_W-1:0] FLAG_MASK    = 13'h1B88;  // bold, blink, ul, inverse, half, invis
   localparam logic [ATTR_W-1:0] IGNORED_BIT  = 13'h0400;
   localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 13'h0007;

   localparam logic [BYTE_W-1:0] BYTE_ESC  = 8'h1B;
   localparam logic [BYTE_W-1:0] BYTE_LBR  = 8'h5B;  // '['
   localparam logic [BYTE_W-1:0] BYTE_SEMI = 8'h3B;  // ';'
   localparam logic [BYTE_W-1:0] BYTE_END  = 8'h6D;  // 'm'
   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h30;  // '0'

   // SGR codes in emission order; a descriptor carries one mask bit per code
   localparam int NUM_CODES = 9;

   typedef enum logic [3:0] {
      CODE_RESET = 4'd0,
      CODE_INVIS = 4'd1,
      CODE_HALF  = 4'd2,
      CODE_INV   = 4'd3,
      CODE_UL    = 4'd4,
      CODE_BLINK = 4'd5,
      CODE_BOLD  = 4'd6,
      CODE_FG    = 4'd7,
      CODE_BG    = 4'd8
   } code_type;

   typedef struct packed {
      logic [ATTR_W-1:0] old_attr;
      logic [ATTR_W-1:0] new_attr;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
   } rsp_item_type;

   // one queued escape sequence: which codes to emit and the color digits
   typedef struct packed {
      logic [NUM_CODES-1:0] mask;
      logic [COLOR_W-1:0]   fg;
      logic [COLOR_W-1:0]   bg;
   } desc_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   // leading character of each code
   function automatic logic [BYTE_W-1:0] code_char(input code_type code);
      logic [BYTE_W-1:0] ch;
      unique case (code)
         CODE_RESET: ch = 8'h30;  // '0'
         CODE_INVIS: ch = 8'h38;  // '8'
         CODE_HALF:  ch = 8'h32;  // '2'
         CODE_INV:   ch = 8'h37;  // '7'
         CODE_UL:    ch = 8'h34;  // '4'
         CODE_BLINK: ch = 8'h35;  // '5'
         CODE_BOLD:  ch = 8'h31;  // '1'
         CODE_FG:    ch = 8'h33;  // '3'
         CODE_BG:    ch = 8'h34;  // '4'
         default:    ch = 8'h30;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

/* hdl/sgr_front.sv */
// Front end: classifies an attribute change into a sequence descriptor.
`default_nettype none

module sgr_front (
   input  var sgr_pkg::req_item_type item,
   output logic                      visible,
   output sgr_pkg::desc_type         desc
);

   logic [sgr_pkg::ATTR_W-1:0] diff;
   logic [sgr_pkg::ATTR_W-1:0] prev_eff;
   logic [sgr_pkg::ATTR_W-1:0] set_bits;
   logic [sgr_pkg::ATTR_W-1:0] eff_diff;
   logic                       cleared;
   logic                       to_default;

   always_comb begin
      diff       = item.old_attr ^ item.new_attr;
      visible    = |(diff & sgr_pkg::VISIBLE_MASK);
      to_default = (item.new_attr & ~sgr_pkg::IGNORED_BIT) == sgr_pkg::DEFAULT_ATTR;
      cleared    = |(item.old_attr & ~item.new_attr & sgr_pkg::FLAG_MASK);
      // after a reset code the terminal sits at the default attributes
      prev_eff   = cleared ? sgr_pkg::DEFAULT_ATTR : item.old_attr;
      set_bits   = item.new_attr & ~prev_eff;
      eff_diff   = prev_eff ^ item.new_attr;

      desc.mask                       = '0;
      desc.mask[sgr_pkg::CODE_RESET]  = cleared;
      desc.mask[sgr_pkg::CODE_INVIS]  = set_bits[12];
      desc.mask[sgr_pkg::CODE_HALF]   = set_bits[11];
      desc.mask[sgr_pkg::CODE_INV]    = set_bits[9];
      desc.mask[sgr_pkg::CODE_UL]     = set_bits[8];
      desc.mask[sgr_pkg::CODE_BLINK]  = set_bits[7];
      desc.mask[sgr_pkg::CODE_BOLD]   = set_bits[3];
      desc.mask[sgr_pkg::CODE_FG]     = |eff_diff[2:0];
      desc.mask[sgr_pkg::CODE_BG]     = |eff_diff[6:4];
      // default target: bare ESC [ m
      if (to_default) begin
         desc.mask = '0;
      end
      desc.fg = item.new_attr[2:0];
      desc.bg = item.new_attr[6:4];
   end

endmodule

`default_nettype wire

/* hdl/sgr_queue.sv */
// Descriptor queue between the front end and the byte sequencer.
`default_nettype none

module sgr_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  var sgr_pkg::desc_type      wr_desc,
   input  logic                       pop,
   output sgr_pkg::desc_type          rd_desc,
   output sgr_pkg::queue_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sgr_pkg::desc_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.valid = count_ff != '0;
   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign rd_desc      = entry_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_desc;
      end
   end

endmodule

`default_nettype wire

/* hdl/sgr_back.sv */
// Back end: walks a descriptor and emits one escape byte per cycle.
`default_nettype none

module sgr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  var sgr_pkg::queue_status_type q_status,
   input  var sgr_pkg::desc_type      q_desc,
   output logic                       q_pop,
   output logic                       rsp_strobe,
   output sgr_pkg::rsp_item_type      rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ESC   = 6'b000010,
      ST_LBR   = 6'b000100,
      ST_CODE  = 6'b001000,
      ST_DIGIT = 6'b010000,
      ST_SEP   = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   logic [sgr_pkg::NUM_CODES-1:0]    mask_ff, mask_in;
   logic [sgr_pkg::COLOR_W-1:0]      fg_ff, fg_in;
   logic [sgr_pkg::COLOR_W-1:0]      bg_ff, bg_in;
   logic                             strobe_ff, strobe_in;
   sgr_pkg::rsp_item_type            rsp_ff, rsp_in;
   sgr_pkg::code_type                cur;
   logic [sgr_pkg::NUM_CODES-1:0]    rest;
   logic                             done;
   logic                             is_color;

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      // lowest pending code goes first
      cur = sgr_pkg::CODE_RESET;
      for (int i = sgr_pkg::NUM_CODES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur = sgr_pkg::code_type'(4'(i));
         end
      end
      rest     = mask_ff & (mask_ff - 1'b1);
      is_color = (cur == sgr_pkg::CODE_FG) || (cur == sgr_pkg::CODE_BG);
   end

   always_comb begin
      state_in           = state_ff;
      mask_in            = mask_ff;
      fg_in              = fg_ff;
      bg_in              = bg_ff;
      strobe_in          = 1'b0;
      rsp_in.out_byte    = sgr_pkg::BYTE_ESC;
      rsp_in.last_byte   = 1'b0;
      done               = 1'b0;
      q_pop              = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_ESC: begin
            strobe_in       = 1'b1;
            rsp_in.out_byte = sgr_pkg::BYTE_ESC;
            state_in        = ST_LBR;
         end
         ST_LBR: begin
            strobe_in       = 1'b1;
            rsp_in.out_byte = sgr_pkg::BYTE_LBR;
            state_in        = (mask_ff != '0) ? ST_CODE : ST_SEP;
         end
         ST_CODE: begin
            strobe_in       = 1'b1;
            rsp_in.out_byte = sgr_pkg::code_char(cur);
            state_in        = is_color ? ST_DIGIT : ST_SEP;
         end
         ST_DIGIT: begin
            strobe_in       = 1'b1;
            rsp_in.out_byte = sgr_pkg::BYTE_ZERO + {5'b0,
                              (cur == sgr_pkg::CODE_FG) ? fg_ff : bg_ff};
            state_in        = ST_SEP;
         end
         ST_SEP: begin
            strobe_in = 1'b1;
            mask_in   = rest;
            if (rest == '0) begin
               rsp_in.out_byte  = sgr_pkg::BYTE_END;
               rsp_in.last_byte = 1'b1;
               done             = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               rsp_in.out_byte = sgr_pkg::BYTE_SEMI;
               state_in        = ST_CODE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // take the next descriptor while idle or as the current sequence finishes
      if (((state_ff == ST_IDLE) || done) && q_status.valid) begin
         q_pop    = 1'b1;
         mask_in  = q_desc.mask;
         fg_in    = q_desc.fg;
         bg_in    = q_desc.bg;
         state_in = ST_ESC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      fg_ff   <= fg_in;
      bg_ff   <= bg_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

/* hdl/sgr_attribute_change_encoder_core.sv */
// Top level of the SGR attribute change encoder: front end, queue, byte sequencer.
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_data          in         start && !busy
//   response  rsp_strobe, rsp_data           out        strobe, one cycle, no stall
//
// A request is classified in the cycle it is accepted and, if any visible
// attribute changes, its descriptor enters the queue; unchanged requests drop.
// The sequencer emits one byte per cycle, 3 to 20 bytes per sequence, and
// starts the next queued sequence in the cycle after the previous last byte,
// so a steady stream leaves no gap between sequences at the output register.
// busy is high only while the queue is full; the response side never stalls.
// Reset (synchronous, active high) empties the queue and idles the sequencer;
// a taken request reaches the output through the queue, the sequencer state and the output register.
`default_nettype none

module sgr_attribute_change_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  var sgr_pkg::req_item_type  req_data,
   output logic                       rsp_strobe,
   output sgr_pkg::rsp_item_type      rsp_data
);

   logic                       visible;
   logic                       accept;
   logic                       q_pop;
   sgr_pkg::desc_type          front_desc;
   sgr_pkg::desc_type          q_desc;
   sgr_pkg::queue_status_type  q_status;

   // hold off new words only when the queue has no room
   assign busy   = q_status.full;
   assign accept = start && !busy;

   sgr_front u_front (
      .item    (req_data),
      .visible (visible),
      .desc    (front_desc)
   );

   // drop words with no visible change: they yield no bytes
   sgr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept && visible),
      .wr_desc (front_desc),
      .pop     (q_pop),
      .rd_desc (q_desc),
      .status  (q_status)
   );

   sgr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_desc     (q_desc),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // every sequence ends in 'm'
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_byte |-> rsp_data.out_byte == sgr_pkg::BYTE_END)
      else $error("final byte of a sequence is not m");

   // ESC is always followed at once by '['
   a_esc_then_lbr: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_byte && rsp_data.out_byte == sgr_pkg::BYTE_ESC
      |=> rsp_strobe && rsp_data.out_byte == sgr_pkg::BYTE_LBR)
      else $error("ESC not followed by [");

   // after a last byte comes either silence or the ESC of the next sequence
   a_no_orphan_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_byte
      |=> !rsp_strobe || rsp_data.out_byte == sgr_pkg::BYTE_ESC)
      else $error("byte after a last byte does not start a new sequence");

endmodule

`default_nettype wire

/* sim/sgr_attribute_change_encoder_core_tb.sv */
// Self-checking testbench for the SGR attribute change encoder core.
`default_nettype none

module sgr_attribute_change_encoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sgr_pkg::*;

   typedef logic [ATTR_W-1:0] attr_word_t;

   // Bit positions of the flag attributes in an attribute word.
   localparam int BIT_BOLD  = 3;
   localparam int BIT_BLINK = 7;
   localparam int BIT_UL    = 8;
   localparam int BIT_INV   = 9;
   localparam int BIT_HALF  = 11;
   localparam int BIT_INVIS = 12;

   // Leading characters of the SGR codes.
   localparam logic [BYTE_W-1:0] CH_RESET = "0";
   localparam logic [BYTE_W-1:0] CH_INVIS = "8";
   localparam logic [BYTE_W-1:0] CH_HALF  = "2";
   localparam logic [BYTE_W-1:0] CH_INV   = "7";
   localparam logic [BYTE_W-1:0] CH_UL    = "4";
   localparam logic [BYTE_W-1:0] CH_BLINK = "5";
   localparam logic [BYTE_W-1:0] CH_BOLD  = "1";
   localparam logic [BYTE_W-1:0] CH_FG    = "3";
   localparam logic [BYTE_W-1:0] CH_BG    = "4";

   localparam int MAX_GAP      = 24;    // longest sender pause, in cycles
   localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 30;    // pipeline latency plus one long sequence
   localparam int MAX_REPORTS  = 30;    // keep the log short on a badly broken block

   logic         clock;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   logic         busy;
   req_item_type req_data = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_data;

   rsp_item_type pending_escape_bytes [$];  // bytes predicted but not yet seen
   int           mismatch_count = 0;
   int           quiet_cycles   = 0;
   int           sender_idle_pct = 0;

   sgr_attribute_change_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the escape sequence for one attribute change and queue its bytes.
   function automatic void predict_escape_bytes(input attr_word_t was, input attr_word_t want);
      attr_word_t        base;
      attr_word_t        raised;
      logic [BYTE_W-1:0] seq [$];
      rsp_item_type      word;
      base = was;
      // Drop the change entirely when nothing visible differs.
      if (((was ^ want) & VISIBLE_MASK) == '0) return;
      seq.push_back(BYTE_ESC);
      seq.push_back(BYTE_LBR);
      if ((want & ~IGNORED_BIT) == DEFAULT_ATTR) begin
         // Going back to the default attributes: the short form ESC [ m.
         seq.push_back(BYTE_END);
      end else begin
         // A cleared flag forces a full reset; compare against the default after it.
         if ((base & ~want & FLAG_MASK) != '0) begin
            seq.push_back(CH_RESET); seq.push_back(BYTE_SEMI);
            base = DEFAULT_ATTR;
         end
         raised = want & ~base;
         if (raised[BIT_INVIS]) begin seq.push_back(CH_INVIS); seq.push_back(BYTE_SEMI); end
         if (raised[BIT_HALF])  begin seq.push_back(CH_HALF);  seq.push_back(BYTE_SEMI); end
         if (raised[BIT_INV])   begin seq.push_back(CH_INV);   seq.push_back(BYTE_SEMI); end
         if (raised[BIT_UL])    begin seq.push_back(CH_UL);    seq.push_back(BYTE_SEMI); end
         if (raised[BIT_BLINK]) begin seq.push_back(CH_BLINK); seq.push_back(BYTE_SEMI); end
         if (raised[BIT_BOLD])  begin seq.push_back(CH_BOLD);  seq.push_back(BYTE_SEMI); end
         if (base[2:0] != want[2:0]) begin
            seq.push_back(CH_FG);
            seq.push_back(BYTE_ZERO + BYTE_W'(want[2:0]));
            seq.push_back(BYTE_SEMI);
         end
         if (base[6:4] != want[6:4]) begin
            seq.push_back(CH_BG);
            seq.push_back(BYTE_ZERO + BYTE_W'(want[6:4]));
            seq.push_back(BYTE_SEMI);
         end
         // The trailing separator turns into the terminator.
         seq[seq.size()-1] = BYTE_END;
      end
      foreach (seq[i]) begin
         word.out_byte  = seq[i];
         word.last_byte = (i == seq.size() - 1);
         pending_escape_bytes.push_back(word);
      end
   endfunction

   // Offer one attribute change, after a random pause, and hold it until taken.
   task automatic send_attr_change(input attr_word_t was, input attr_word_t want);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // Leave start high on return so back-to-back words need no extra edge.
      start    <= 1'b1;
      req_data <= '{old_attr: was, new_attr: want};
      do @(posedge clock); while (busy);
      predict_escape_bytes(was, want);
   endtask

   // Check each emitted byte against the oldest prediction, field by field.
   always @(posedge clock) begin
      rsp_item_type exp_word;
      if (!reset && rsp_strobe) begin
         if (pending_escape_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected byte: expected none, actual byte %h last %b",
                        $time, rsp_data.out_byte, rsp_data.last_byte);
         end else begin
            exp_word = pending_escape_bytes.pop_front();
            if (rsp_data.out_byte !== exp_word.out_byte) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $time, exp_word.out_byte, rsp_data.out_byte);
            end
            if (rsp_data.last_byte !== exp_word.last_byte) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: last_byte mismatch: expected %b, actual %b",
                           $time, exp_word.last_byte, rsp_data.last_byte);
            end
         end
      end
   end

   // Count cycles in which no word moves on either side; give up when it runs long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Corner cases: no visible change, default target, cleared flags, every code.
   task automatic test_directed_cases();
      attr_word_t pairs [][2];
      sender_idle_pct = 0;
      pairs = '{
         '{13'h0000, 13'h0000},  // identical words
         '{13'h1FFF, 13'h1FFF},
         '{13'h0000, 13'h0400},  // only the ignored bit moves
         '{13'h1BFF, 13'h1FFF},
         '{13'h0000, 13'h0007},  // default target
         '{13'h1FFF, 13'h0007},
         '{13'h1FFF, 13'h0407},  // default target, ignored bit set
         '{13'h0008, 13'h0000},  // bold cleared
         '{13'h1B88, 13'h0888},  // invisible, inverse and underline cleared, the rest raised again
         '{13'h0007, 13'h1BF8},  // every flag and both colors
         '{13'h0000, 13'h1FFF},
         '{13'h1FFF, 13'h0000},
         '{13'h0007, 13'h1007},  // one flag raised at a time
         '{13'h0007, 13'h0807},
         '{13'h0007, 13'h0207},
         '{13'h0007, 13'h0107},
         '{13'h0007, 13'h0087},
         '{13'h0007, 13'h000F},
         '{13'h0070, 13'h0071},  // foreground only
         '{13'h0007, 13'h0077},  // background only
         '{13'h0000, 13'h0006},
         '{13'h0FFF, 13'h0F00},
         '{13'h1000, 13'h1808}
      };
      foreach (pairs[i]) send_attr_change(pairs[i][0], pairs[i][1]);
   endtask

   // Random changes: random words, a few flipped bits, default targets, ignored-bit no-ops, cleared flags.
   task automatic test_random_traffic(input int count, input int idle_pct);
      attr_word_t was;
      attr_word_t want;
      int         kind;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         was  = attr_word_t'($urandom);
         kind = $urandom_range(99);
         if (kind < 25) begin
            want = attr_word_t'($urandom);
         end else if (kind < 60) begin
            // Flip a handful of bits: the usual case of a small attribute change.
            want = was;
            repeat ($urandom_range(3, 1)) want[$urandom_range(ATTR_W-1)] ^= 1'b1;
         end else if (kind < 72) begin
            want = DEFAULT_ATTR | (IGNORED_BIT & attr_word_t'($urandom));
         end else if (kind < 80) begin
            want = was ^ (IGNORED_BIT & attr_word_t'($urandom));
         end else begin
            // Clear some flags and move the colors.
            want = (was & ~(FLAG_MASK & attr_word_t'($urandom)))
                   ^ (attr_word_t'($urandom) & 13'h0077);
         end
         send_attr_change(was, want);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(90, 0);
      test_random_traffic(90, 71);
      test_random_traffic(90, 35);
      start <= 1'b0;
      // Hold until every predicted byte is out, then watch for strays.
      while (pending_escape_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hdl/sgr_pkg.sv
hdl/sgr_front.sv
hdl/sgr_queue.sv
hdl/sgr_back.sv
hdl/sgr_attribute_change_encoder_core.sv
sim/sgr_attribute_change_encoder_core_tb.sv
